[sv/wrst_pkg.sv]
// ----------------------------------------------------------------------------
// wrst_pkg
// Shared widths, opcodes and sequencer states for the weighted select tree.
// ----------------------------------------------------------------------------
package wrst_pkg;

    // item field widths
    localparam int IDX_W      = 6;
    localparam int WGT_IN_W   = 16;
    localparam int FRAC_IN_W  = 32;
    localparam int TOTAL_W    = 22;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;

    typedef enum logic
    {
        OP_SET    = 1'b0,
        OP_SELECT = 1'b1
    } op_t;

    typedef enum logic [10:0]
    {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_UP_RD  = 11'b000_0000_0100,
        ST_UP_SUM = 11'b000_0000_1000,
        ST_MUL    = 11'b000_0001_0000,
        ST_DN_RD  = 11'b000_0010_0000,
        ST_DN_W   = 11'b000_0100_0000,
        ST_DN_L   = 11'b000_1000_0000,
        ST_DN_R   = 11'b001_0000_0000,
        ST_DONE   = 11'b010_0000_0000,
        ST_SPARE  = 11'b100_0000_0000
    } state_t;

endpackage

[sv/weighted_random_select_tree_top.sv]
// Set item: the update walk reads and sums each level from the entry to the root
// (ST_UP_RD, ST_UP_SUM). Select item: FRACTION_BITS multiply steps, then up to
// ST_DN_RD, ST_DN_W, ST_DN_L, ST_DN_R per level descended; zero total: ST_DONE.
// Items are taken only in ST_IDLE; the next item is taken while a result
// waits at the output. Reset: a clearing pass of ENTRIES cycles after rst_n
// releases zeroes both tables; no item is accepted until it is done.
// ----------------------------------------------------------------------------
// weighted_random_select_tree_top
// Weighted random entry select over a heap-ordered binary sum tree, with separate
// adders and a shared descent subtractor driven by a small sequencer.
// ----------------------------------------------------------------------------
module weighted_random_select_tree_top #(
    parameter int ENTRIES       = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_index[5:0], new_weight[21:6], random_fraction[53:22], zero pad
    input  logic [wrst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  logic [wrst_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // selected_entry[5:0], total_weight[27:6], zero pad
    output logic [wrst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // none_available[0]
    output logic [wrst_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import wrst_pkg::*;

    localparam int NODE_BITS = $clog2(ENTRIES);
    localparam int SUM_BITS  = WEIGHT_BITS + NODE_BITS;
    localparam int CNT_BITS  = $clog2(FRACTION_BITS);

    // tables
    logic [WEIGHT_BITS-1:0] wmem [ENTRIES];
    logic [SUM_BITS-1:0]    smem [ENTRIES];

    state_t                 state_reg, state_next;
    logic [NODE_BITS-1:0]   node_reg, node_next;
    logic [SUM_BITS-1:0]    pos_reg, pos_next;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]    total_reg, total_next;
    logic                   none_reg, none_next;
    logic [NODE_BITS-1:0]   clr_reg, clr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic [WEIGHT_BITS-1:0] w_rd_reg;
    logic [SUM_BITS-1:0]    sl_rd_reg;
    logic [SUM_BITS-1:0]    sr_rd_reg;

    logic                   accept;
    op_t                    op_in;
    logic [IDX_W-1:0]       idx_in;
    logic [WGT_IN_W-1:0]    wgt_in;
    logic [FRAC_IN_W-1:0]   frac_in;
    logic                   idx_ok;
    logic                   out_free;

    logic [NODE_BITS+1:0]   l_child, r_child;
    logic                   l_ok, r_ok;
    logic [NODE_BITS-1:0]   l_addr, r_addr;
    logic [SUM_BITS-1:0]    l_sum, r_sum, up_sum;

    logic                   wmem_we, smem_we;
    logic [NODE_BITS-1:0]   wmem_addr, smem_addr;
    logic [WEIGHT_BITS-1:0] wmem_wdata;
    logic [SUM_BITS-1:0]    smem_wdata;

    // multiply-step adder (ST_MUL); subtractor shared by ST_DN_W, ST_DN_L and ST_DN_R
    logic [SUM_BITS:0]      mul_add;
    logic [SUM_BITS-1:0]    sub_opnd;
    logic [SUM_BITS:0]      sub_res;
    logic                   sub_borrow;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op_in         = op_t'(s_axis_tuser[0]);
    assign idx_in        = s_axis_tdata[IDX_W-1:0];
    assign wgt_in        = s_axis_tdata[IDX_W +: WGT_IN_W];
    assign frac_in       = s_axis_tdata[IDX_W+WGT_IN_W +: FRAC_IN_W];
    assign idx_ok        = (32'(idx_in) < ENTRIES);
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // children of the current node; missing ones read as zero weight
    assign l_child = {1'b0, node_reg, 1'b1};
    assign r_child = {1'b0, node_reg, 1'b0} + (NODE_BITS+2)'(2);
    assign l_ok    = (32'(l_child) < ENTRIES);
    assign r_ok    = (32'(r_child) < ENTRIES);
    assign l_addr  = l_ok ? l_child[NODE_BITS-1:0] : '0;
    assign r_addr  = r_ok ? r_child[NODE_BITS-1:0] : '0;
    assign l_sum   = l_ok ? sl_rd_reg : '0;
    assign r_sum   = r_ok ? sr_rd_reg : '0;
    assign up_sum  = SUM_BITS'(w_rd_reg) + l_sum + r_sum;

    assign mul_add = {1'b0, pos_reg} + (frac_reg[0] ? {1'b0, total_reg} : '0);

    always_comb
    begin
        case (state_reg)
            ST_DN_W: sub_opnd = SUM_BITS'(w_rd_reg);
            ST_DN_L: sub_opnd = l_sum;
            ST_DN_R: sub_opnd = r_sum;
            default: sub_opnd = '0;
        endcase
    end

    assign sub_res    = {1'b0, pos_reg} - {1'b0, sub_opnd};
    assign sub_borrow = sub_res[SUM_BITS];

    // table write ports
    always_comb
    begin
        wmem_we    = 1'b0;
        wmem_addr  = NODE_BITS'(idx_in);
        wmem_wdata = WEIGHT_BITS'(wgt_in);
        smem_we    = 1'b0;
        smem_addr  = node_reg;
        smem_wdata = up_sum;
        if (state_reg == ST_CLEAR)
        begin
            wmem_we    = 1'b1;
            wmem_addr  = clr_reg;
            wmem_wdata = '0;
            smem_we    = 1'b1;
            smem_addr  = clr_reg;
            smem_wdata = '0;
        end
        else if (accept && op_in == OP_SET && idx_ok)
        begin
            wmem_we = 1'b1;
        end
        else if (state_reg == ST_UP_SUM)
        begin
            smem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wmem_we)
        begin
            wmem[wmem_addr] <= wmem_wdata;
        end
        if (smem_we)
        begin
            smem[smem_addr] <= smem_wdata;
        end
        w_rd_reg  <= wmem[node_reg];
        sl_rd_reg <= smem[l_addr];
        sr_rd_reg <= smem[r_addr];
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        node_next     = node_reg;
        pos_next      = pos_reg;
        frac_next     = frac_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        none_next     = none_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NODE_BITS'(ENTRIES-1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    none_next = 1'b0;
                    node_next = '0;
                    if (op_in == OP_SET)
                    begin
                        if (idx_ok)
                        begin
                            node_next  = NODE_BITS'(idx_in);
                            state_next = ST_UP_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (total_reg == '0)
                    begin
                        none_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = '0;
                        frac_next  = FRACTION_BITS'(frac_in);
                        cnt_next   = CNT_BITS'(FRACTION_BITS-1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_UP_RD:
            begin
                state_next = ST_UP_SUM;
            end
            ST_UP_SUM:
            begin
                if (node_reg == '0)
                begin
                    total_next = up_sum;
                    state_next = ST_DONE;
                end
                else
                begin
                    node_next  = (node_reg - 1'b1) >> 1;
                    state_next = ST_UP_RD;
                end
            end
            ST_MUL:
            begin
                // LSB-first shift-add; keeps floor(frac * total / 2^FRACTION_BITS)
                pos_next  = mul_add[SUM_BITS:1];
                frac_next = frac_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_RD:
            begin
                state_next = ST_DN_W;
            end
            ST_DN_W:
            begin
                if (sub_borrow)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next   = sub_res[SUM_BITS-1:0];
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L:
            begin
                if (sub_borrow)
                begin
                    node_next  = l_addr;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    pos_next   = sub_res[SUM_BITS-1:0];
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R:
            begin
                if (sub_borrow)
                begin
                    node_next  = r_addr;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({TOTAL_W'(total_reg), IDX_W'(node_reg)});
                    m_tuser_next  = M_TUSER_W'(none_reg);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            total_reg    <= '0;
            none_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            total_reg    <= total_next;
            none_reg     <= none_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        pos_reg     <= pos_next;
        frac_reg    <= frac_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // position never reaches the total while scaling or descending
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DN_W || state_reg == ST_DN_L ||
         state_reg == ST_DN_R) |-> (pos_reg < total_reg))
        else $error("descent position out of range");

    // the update walk always moves toward the root
    a_up_toward_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_SUM && node_reg != '0) |=> (node_reg < $past(node_reg)))
        else $error("update walk did not move toward root");

    // select on an empty tree finishes at once and flags none
    a_empty_select: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_in == OP_SELECT && total_reg == '0)
        |=> (state_reg == ST_DONE && none_reg && node_reg == '0))
        else $error("empty select not flagged");

    // total is stable for the whole of a select
    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DN_RD || state_reg == ST_DN_W ||
         state_reg == ST_DN_L || state_reg == ST_DN_R) |=> $stable(total_reg))
        else $error("total changed during select");

endmodule
